// File: rtl/nnds_pkg.sv
// Shared types and constants for the nearest-neighbor pixel downscaler.
// Used by the register block, the selection logic and the top level.
package nnds_pkg;

  localparam int unsigned DEF_MAX_DIMENSION_BITS = 12;
  localparam int unsigned CFG_REG_W = 13;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned PIXEL_W = 8;

  localparam logic [1:0] REG_SOURCE_WIDTH = 2'd0;
  localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE_NUMERATOR = 2'd2;
  localparam logic [1:0] REG_SCALE_DENOMINATOR = 2'd3;

  typedef struct packed {
    logic keep;
    logic row_end;
    logic frame_end;
  } sel_result_t;

endpackage

// File: rtl/nearest_neighbor_pixel_downscaler_unit.sv
// Top level of the nearest-neighbor pixel downscaler: input and output beat
// registers around the selection logic. Depends on nnds_pkg, nnds_scale_cfg
// and nnds_select.

// The block takes one source pixel per clock cycle in raster order while
// the output is not stalled and passes on the pixels that nearest-neighbor
// shrinking by numerator/denominator selects, flagging the last pixel of
// each output row and of the frame. A pixel beat is registered on entry in
// the stage registers, and a kept pixel is then registered in the output
// registers; the rate is set by the combinational add-and-compare decision
// in the selection logic. Register writes pass through the configuration
// registers and then the registered derived limits, and the position
// counters wrap to zero after the last source pixel of each frame.
module nearest_neighbor_pixel_downscaler_unit #(
  parameter int unsigned MAX_DIMENSION_BITS = nnds_pkg::DEF_MAX_DIMENSION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nnds_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [nnds_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [nnds_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nnds_pkg::PIXEL_W-1:0]      in_blue,
  input  logic [nnds_pkg::PIXEL_W-1:0]      in_green,
  input  logic [nnds_pkg::PIXEL_W-1:0]      in_red,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nnds_pkg::PIXEL_W-1:0]      out_blue,
  output logic [nnds_pkg::PIXEL_W-1:0]      out_green,
  output logic [nnds_pkg::PIXEL_W-1:0]      out_red,
  output logic                              row_end,
  output logic                              frame_end
);

  localparam int unsigned B = MAX_DIMENSION_BITS;
  localparam int unsigned PW = nnds_pkg::PIXEL_W;

  logic [B:0] width_clamped;
  logic [B:0] height_clamped;
  logic [B:0] num;
  logic [B:0] den;
  logic [B+1:0] den_twice;
  logic [2*B:0] width_limit;
  logic [2*B:0] height_limit;

  logic stage_valid;
  logic [PW-1:0] stage_blue;
  logic [PW-1:0] stage_green;
  logic [PW-1:0] stage_red;
  logic advance;
  logic step;
  nnds_pkg::sel_result_t result;

  nnds_scale_cfg #(
    .MAX_DIMENSION_BITS(MAX_DIMENSION_BITS)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .width_clamped(width_clamped),
    .height_clamped(height_clamped),
    .num(num),
    .den(den),
    .den_twice(den_twice),
    .width_limit(width_limit),
    .height_limit(height_limit)
  );

  assign advance = !out_valid || !out_stall;
  assign step = stage_valid && advance;
  assign in_stall = stage_valid && !advance;

  nnds_select #(
    .MAX_DIMENSION_BITS(MAX_DIMENSION_BITS)
  ) u_select (
    .clk(clk),
    .rst(rst),
    .step(step),
    .width_clamped(width_clamped),
    .height_clamped(height_clamped),
    .num(num),
    .den(den),
    .den_twice(den_twice),
    .width_limit(width_limit),
    .height_limit(height_limit),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_blue <= in_blue;
      stage_green <= in_green;
      stage_red <= in_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && result.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.keep) begin
      out_blue <= stage_blue;
      out_green <= stage_green;
      out_red <= stage_red;
      row_end <= result.row_end;
      frame_end <= result.frame_end;
    end
  end

  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!frame_end || row_end))
    else $error("frame end flagged without row end");

  a_kept_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (step && result.keep) |=> out_valid)
    else $error("kept pixel did not reach the output register");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |=> stage_valid)
    else $error("input stage lost a beat while the output was stalled");

endmodule

// File: rtl/nnds_scale_cfg.sv
// Configuration registers behind the APB port, plus the registered clamped
// dimensions and scaled limits. Depends on nnds_pkg.
module nnds_scale_cfg #(
  parameter int unsigned MAX_DIMENSION_BITS = nnds_pkg::DEF_MAX_DIMENSION_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nnds_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [nnds_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [nnds_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output logic [MAX_DIMENSION_BITS:0]          width_clamped,
  output logic [MAX_DIMENSION_BITS:0]          height_clamped,
  output logic [MAX_DIMENSION_BITS:0]          num,
  output logic [MAX_DIMENSION_BITS:0]          den,
  output logic [MAX_DIMENSION_BITS+1:0]        den_twice,
  output logic [2*MAX_DIMENSION_BITS:0]        width_limit,
  output logic [2*MAX_DIMENSION_BITS:0]        height_limit
);

  localparam int unsigned B = MAX_DIMENSION_BITS;
  localparam int unsigned DW = B + 1;
  localparam int unsigned AW = 2 * B + 1;
  localparam int unsigned RW = nnds_pkg::CFG_REG_W;
  localparam int unsigned XW = (B + 2 > RW) ? B + 2 : RW;

  logic [RW-1:0] source_width;
  logic [RW-1:0] source_height;
  logic [RW-1:0] scale_numerator;
  logic [RW-1:0] scale_denominator;

  logic [DW-1:0] w_c;
  logic [DW-1:0] h_c;
  logic [DW-1:0] n_c;
  logic [DW-1:0] d_c;
  logic [DW-1:0] n_min;
  logic [2*DW-1:0] w_prod;
  logic [2*DW-1:0] h_prod;
  logic wr_en;

  function automatic logic [DW-1:0] clamp_dim(input logic [RW-1:0] v);
    logic [XW-1:0] vx;
    logic [XW-1:0] top;
    vx = XW'(v);
    top = XW'(1) << B;
    if (vx == '0) begin
      clamp_dim = DW'(1);
    end else if (vx > top) begin
      clamp_dim = DW'(top);
    end else begin
      clamp_dim = DW'(vx);
    end
  endfunction

  assign wr_en = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= RW'(1);
      source_height <= RW'(1);
      scale_numerator <= RW'(1);
      scale_denominator <= RW'(1);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        nnds_pkg::REG_SOURCE_WIDTH: source_width <= pwdata[RW-1:0];
        nnds_pkg::REG_SOURCE_HEIGHT: source_height <= pwdata[RW-1:0];
        nnds_pkg::REG_SCALE_NUMERATOR: scale_numerator <= pwdata[RW-1:0];
        nnds_pkg::REG_SCALE_DENOMINATOR: scale_denominator <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      nnds_pkg::REG_SOURCE_WIDTH: prdata = nnds_pkg::APB_DATA_W'(source_width);
      nnds_pkg::REG_SOURCE_HEIGHT: prdata = nnds_pkg::APB_DATA_W'(source_height);
      nnds_pkg::REG_SCALE_NUMERATOR: prdata = nnds_pkg::APB_DATA_W'(scale_numerator);
      nnds_pkg::REG_SCALE_DENOMINATOR: prdata = nnds_pkg::APB_DATA_W'(scale_denominator);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    w_c = clamp_dim(source_width);
    h_c = clamp_dim(source_height);
    n_c = clamp_dim(scale_numerator);
    d_c = clamp_dim(scale_denominator);
    n_min = (n_c > d_c) ? d_c : n_c;
    w_prod = w_c * n_min;
    h_prod = h_c * n_min;
  end

  always_ff @(posedge clk) begin
    width_clamped <= w_c;
    height_clamped <= h_c;
    num <= n_min;
    den <= d_c;
    den_twice <= {d_c, 1'b0};
    width_limit <= w_prod[AW-1:0];
    height_limit <= h_prod[AW-1:0];
  end

endmodule

// File: rtl/nnds_select.sv
// Source position counters and rational accumulators that decide which
// source pixels are kept and where output rows and the frame end.
// Depends on nnds_pkg.
module nnds_select #(
  parameter int unsigned MAX_DIMENSION_BITS = nnds_pkg::DEF_MAX_DIMENSION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [MAX_DIMENSION_BITS:0]       width_clamped,
  input  logic [MAX_DIMENSION_BITS:0]       height_clamped,
  input  logic [MAX_DIMENSION_BITS:0]       num,
  input  logic [MAX_DIMENSION_BITS:0]       den,
  input  logic [MAX_DIMENSION_BITS+1:0]     den_twice,
  input  logic [2*MAX_DIMENSION_BITS:0]     width_limit,
  input  logic [2*MAX_DIMENSION_BITS:0]     height_limit,
  output nnds_pkg::sel_result_t             result
);

  localparam int unsigned B = MAX_DIMENSION_BITS;
  localparam int unsigned DW = B + 1;
  localparam int unsigned AW = 2 * B + 1;

  logic [B-1:0] source_column;
  logic [B-1:0] source_row;
  logic [AW-1:0] column_target_sum;
  logic [AW-1:0] column_source_sum;
  logic [AW-1:0] row_target_sum;
  logic [AW-1:0] row_source_sum;
  logic row_kept;

  logic [B-1:0] source_column_next;
  logic [B-1:0] source_row_next;
  logic [AW-1:0] column_target_sum_next;
  logic [AW-1:0] column_source_sum_next;
  logic [AW-1:0] row_target_sum_next;
  logic [AW-1:0] row_source_sum_next;
  logic row_kept_next;

  logic [AW-1:0] num_x;
  logic [AW-1:0] den_x;
  logic [AW-1:0] den2_x;
  logic row_start;
  logic row_take;
  logic row_on;
  logic [AW-1:0] row_target_now;
  logic [AW-1:0] row_target_ahead;
  logic col_take;
  logic last_col;
  logic last_row;

  always_comb begin
    num_x = AW'(num);
    den_x = AW'(den);
    den2_x = AW'(den_twice);
    row_start = (source_column == '0);
    row_take = (row_target_sum < row_source_sum + num_x) &&
               (row_target_sum + den_x <= height_limit);
    row_on = row_start ? row_take : row_kept;
    row_target_now = (row_start && row_take) ? row_target_sum + den_x : row_target_sum;
    row_target_ahead = (row_start && row_take) ? row_target_sum + den2_x
                                                : row_target_sum + den_x;
    col_take = row_on && (column_target_sum < column_source_sum + num_x) &&
               (column_target_sum + den_x <= width_limit);
    result.keep = col_take;
    result.row_end = col_take && (column_target_sum + den2_x > width_limit);
    result.frame_end = result.row_end && (row_target_ahead > height_limit);

    last_col = (DW'(source_column) + DW'(1)) >= width_clamped;
    last_row = (DW'(source_row) + DW'(1)) >= height_clamped;

    source_column_next = source_column + B'(1);
    source_row_next = source_row;
    column_target_sum_next = col_take ? column_target_sum + den_x : column_target_sum;
    column_source_sum_next = column_source_sum + num_x;
    row_target_sum_next = row_target_now;
    row_source_sum_next = row_source_sum;
    row_kept_next = row_on;
    if (last_col) begin
      source_column_next = '0;
      column_source_sum_next = '0;
      column_target_sum_next = '0;
      if (!last_row) begin
        source_row_next = source_row + B'(1);
        row_source_sum_next = row_source_sum + num_x;
      end else begin
        source_row_next = '0;
        row_source_sum_next = '0;
        row_target_sum_next = '0;
        row_kept_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_column <= '0;
      source_row <= '0;
      column_target_sum <= '0;
      column_source_sum <= '0;
      row_target_sum <= '0;
      row_source_sum <= '0;
      row_kept <= 1'b0;
    end else if (step) begin
      source_column <= source_column_next;
      source_row <= source_row_next;
      column_target_sum <= column_target_sum_next;
      column_source_sum <= column_source_sum_next;
      row_target_sum <= row_target_sum_next;
      row_source_sum <= row_source_sum_next;
      row_kept <= row_kept_next;
    end
  end

endmodule
